FILE: rtl/scpu_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// scpu_pkg
// Shared types and constants for the 16-bit machine execute step.
// ----------------------------------------------------------------------------
package scpu_pkg;

  localparam int WORD_W  = 16;
  localparam int PC_W    = 8;
  localparam int DMEM_DEPTH = 256;
  localparam int NUM_PORTS  = 8;
  localparam int NUM_REGS_DEF    = 8;
  localparam int STACK_DEPTH_DEF = 16;
  localparam logic [31:0] STEP_LIMIT_RST = 32'hFFFF_FFFF;

  typedef enum logic [4:0] {
    OP_NOP = 5'd0, OP_HLT = 5'd1, OP_ADD = 5'd2, OP_SUB = 5'd3, OP_MUL = 5'd4,
    OP_DIV = 5'd5, OP_MOD = 5'd6, OP_AND = 5'd7, OP_OR = 5'd8, OP_XOR = 5'd9,
    OP_SHL = 5'd10, OP_SHR = 5'd11, OP_ASR = 5'd12, OP_CMP = 5'd13,
    OP_LD = 5'd14, OP_ST = 5'd15, OP_LDI = 5'd16, OP_LUI = 5'd17,
    OP_ADDI = 5'd18, OP_BR = 5'd19, OP_JMP = 5'd20, OP_CALL = 5'd21,
    OP_RET = 5'd22, OP_IN = 5'd23, OP_OUT = 5'd24
  } opcode_t;

  typedef enum logic [1:0] {
    ST_RUN = 2'd0, ST_HALT = 2'd1, ST_TIMEOUT = 2'd2, ST_FAULT = 2'd3
  } run_t;

  typedef enum logic [2:0] {
    BC_AL = 3'd0, BC_EQ = 3'd1, BC_NE = 3'd2, BC_LT = 3'd3,
    BC_GE = 3'd4, BC_LTU = 3'd5, BC_GEU = 3'd6, BC_NV = 3'd7
  } brcond_t;

  localparam logic [1:0] REG_STEP_LIMIT = 2'd0;

  // controller -> datapath
  typedef struct packed {
    logic capture;   // latch the accepted item, read operands
    logic exec;      // operands ready, run non-divide ops / decide
    logic div_start; // launch the divider
    logic commit;    // write back the result
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic running;   // status is running and count is below the limit
    logic is_div;    // div/mod with a nonzero divisor
    logic div_done;
  } dp_stat_t;

endpackage
`default_nettype wire

FILE: rtl/scpu_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// scpu_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module scpu_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output      logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

FILE: rtl/scpu_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// scpu_div
// Radix-2 signed divider, truncating; one quotient bit per cycle.
// ----------------------------------------------------------------------------
module scpu_div (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [15:0] dividend,
  input  wire logic [15:0] divisor,
  output      logic        done,
  output      logic [15:0] quotient,
  output      logic [15:0] remainder
);
  logic [15:0] q, dv;
  logic [16:0] r;
  logic [4:0]  cnt;
  logic        busy, neg_q, neg_r;
  logic [16:0] trial;
  logic [16:0] r_shift;

  assign r_shift = {r[15:0], q[15]};
  assign trial   = r_shift - {1'b0, dv};
  assign quotient  = neg_q ? 16'(-q) : q;
  assign remainder = neg_r ? 16'(-r[15:0]) : r[15:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        cnt   <= 5'd16;
        q     <= dividend[15] ? 16'(-dividend) : dividend;
        dv    <= divisor[15] ? 16'(-divisor) : divisor;
        r     <= '0;
        neg_q <= dividend[15] ^ divisor[15];
        neg_r <= dividend[15];
      end else if (busy) begin
        // restoring step
        if (!trial[16]) begin
          r <= trial;
          q <= {q[14:0], 1'b1};
        end else begin
          r <= r_shift;
          q <= {q[14:0], 1'b0};
        end
        cnt <= cnt - 5'd1;
        if (cnt == 5'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

`ifndef SYNTH
  a_done_pulse: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("divider done held");
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("divider done without busy");
  a_cnt_busy: assert property (@(posedge clk) disable iff (rst)
    busy |-> cnt != 5'd0)
    else $error("divider count ran out while busy");
`endif
endmodule
`default_nettype wire

FILE: rtl/scpu_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// scpu_ctrl
// Step sequencer: capture, execute, optional divide wait, commit, output.
// ----------------------------------------------------------------------------
module scpu_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output      logic               in_stall,
  input  wire logic               out_stall,
  output      logic               out_valid,
  output      scpu_pkg::dp_cmd_t  cmd,
  input  wire scpu_pkg::dp_stat_t stat
);
  import scpu_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_EXEC, S_DIV, S_COMMIT, S_OUT} state_t;
  state_t state;

  // input taken only when idle, or when the held result leaves this cycle
  logic take;
  assign in_stall = rst || !(state == S_IDLE || (state == S_OUT && !out_stall));
  assign take     = in_valid && !in_stall;

  always_comb begin
    cmd = '0;
    cmd.capture   = take;
    cmd.exec      = (state == S_EXEC);
    cmd.div_start = (state == S_EXEC) && stat.running && stat.is_div;
    cmd.commit    = (state == S_COMMIT);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: if (take) state <= S_EXEC;
        S_EXEC: state <= (stat.running && stat.is_div) ? S_DIV : S_COMMIT;
        S_DIV: if (stat.div_done) state <= S_COMMIT;
        S_COMMIT: begin
          state     <= S_OUT;
          out_valid <= 1'b1;
        end
        S_OUT: if (!out_stall) begin
          out_valid <= 1'b0;
          state     <= take ? S_EXEC : S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  a_valid_out: assert property (@(posedge clk) disable iff (rst)
    out_valid == (state == S_OUT))
    else $error("out_valid out of step with state");
  a_commit_once: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> !cmd.commit)
    else $error("double commit");
  a_no_take_busy: assert property (@(posedge clk) disable iff (rst)
    (state == S_EXEC || state == S_DIV || state == S_COMMIT) |-> !take)
    else $error("item taken mid-step");
`endif
endmodule
`default_nettype wire

FILE: rtl/scpu_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// scpu_dp
// Architectural state, ALU, branch unit, stack and data memory.
// ----------------------------------------------------------------------------
module scpu_dp #(
  parameter int NUM_REGS    = scpu_pkg::NUM_REGS_DEF,
  parameter int STACK_DEPTH = scpu_pkg::STACK_DEPTH_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire scpu_pkg::dp_cmd_t  cmd,
  output      scpu_pkg::dp_stat_t stat,
  input  wire logic [31:0]        step_limit,
  input  wire logic [4:0]         opcode,
  input  wire logic [2:0]         dest_reg,
  input  wire logic [2:0]         src_reg,
  input  wire logic [2:0]         second_reg,
  input  wire logic [7:0]         immediate,
  input  wire logic               ext_port_valid,
  input  wire logic [15:0]        ext_port_value,
  output      logic [7:0]         next_pc,
  output      logic [1:0]         run_status,
  output      logic [3:0]         flag_bits,
  output      logic               port_write_valid,
  output      logic [2:0]         port_write_index,
  output      logic [15:0]        port_write_value
);
  import scpu_pkg::*;

  localparam int SP_W  = $clog2(STACK_DEPTH + 1);
  localparam int STK_AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

  // architectural state
  logic [15:0] regs [1:NUM_REGS_DEF-1];
  logic [15:0] ports [NUM_PORTS];
  logic [7:0]  stk [STACK_DEPTH];
  logic [3:0]  flags;
  logic [7:0]  pc;
  logic [SP_W-1:0] sp;
  logic [1:0]  status;
  logic [31:0] count;
  // dmem valid bits emulate the zeroed reset
  logic [DMEM_DEPTH-1:0] dm_vld;

  // latched item
  logic [4:0]  op;
  logic [2:0]  rd;
  logic [7:0]  imm;
  logic        epv;
  logic [15:0] epval;

  // operands
  logic [15:0] a, b, d;
  logic        run_ok;

  function automatic logic [15:0] rd_reg(input logic [2:0] i,
                                         input logic [15:0] v);
    rd_reg = (i == 3'd0 || int'(i) >= NUM_REGS) ? 16'd0 : v;
  endfunction

  // register file reads (small, fixed lanes)
  logic [15:0] ra, rb, rdd;
  always_comb begin
    ra = '0; rb = '0; rdd = '0;
    for (int k = 1; k < NUM_REGS_DEF; k++) begin
      if (src_reg == 3'(k))    ra  = regs[k];
      if (second_reg == 3'(k)) rb  = regs[k];
      if (dest_reg == 3'(k))   rdd = regs[k];
    end
  end

  // incoming rs operand
  logic [15:0] cap_a;
  assign cap_a = rd_reg(src_reg, ra);

  // data memory
  logic        dm_we;
  logic [7:0]  dm_addr;
  logic [15:0] dm_rdata, ld_val;
  logic        ld_vld;

  scpu_ram #(.WIDTH(WORD_W), .DEPTH(DMEM_DEPTH)) u_dmem (
    .clk(clk), .we(dm_we), .addr(dm_addr), .wdata(a), .rdata(dm_rdata)
  );
  // address: capture cycle reads using incoming operand; commit writes
  assign dm_addr = cmd.capture ? cap_a[7:0]
                 : (cmd.commit ? d[7:0] : a[7:0]);
  assign dm_we   = cmd.commit && run_ok && op == OP_ST;
  assign ld_val  = ld_vld ? dm_rdata : 16'd0;

  // divider
  logic        div_done;
  logic [15:0] dq, dr;
  scpu_div u_div (
    .clk(clk), .rst(rst), .start(cmd.div_start), .dividend(a), .divisor(b),
    .done(div_done), .quotient(dq), .remainder(dr)
  );

  // execute cycle: non-divide results registered
  logic [15:0] res;
  logic        res_we;
  logic [3:0]  fl_n;
  logic [7:0]  pc_n;
  logic [1:0]  st_n;
  logic        sp_push, sp_pop;

  logic [15:0] e_res;
  logic        e_we;
  logic [3:0]  e_fl;
  logic [7:0]  e_pc;
  logic [1:0]  e_st;
  logic        e_push, e_pop;
  logic [16:0] add_full;
  logic [15:0] sub_r, simm, x_a, x_b, shr_r;
  logic        take;
  logic [7:0]  pc1;

  function automatic logic [3:0] zn(input logic [15:0] r);
    zn = {2'b00, r[15], r == 16'd0};
  endfunction

  always_comb begin
    logic [31:0] prod;
    simm = {{8{imm[7]}}, imm};
    pc1  = pc + 8'd1;
    e_res = '0; e_we = 1'b0; e_fl = flags; e_pc = pc1; e_st = status;
    e_push = 1'b0; e_pop = 1'b0;
    x_a = (op == OP_ADDI) ? d : a;
    x_b = (op == OP_ADDI) ? simm : b;
    add_full = {1'b0, x_a} + {1'b0, x_b};
    sub_r = ((op == OP_CMP) ? d : a) - ((op == OP_CMP) ? a : b);
    shr_r = a >> b[3:0];
    prod  = a * b;
    take  = 1'b0;
    case (brcond_t'(rd))
      BC_AL:  take = 1'b1;
      BC_EQ:  take = flags[0];
      BC_NE:  take = !flags[0];
      BC_LT:  take = flags[1] != flags[3];
      BC_GE:  take = flags[1] == flags[3];
      BC_LTU: take = !flags[2];
      BC_GEU: take = flags[2];
      default: take = 1'b0;
    endcase
    case (op)
      OP_NOP: ;
      OP_HLT: e_st = ST_HALT;
      OP_ADD, OP_ADDI: begin
        e_res = add_full[15:0]; e_we = 1'b1;
        e_fl = zn(add_full[15:0]);
        e_fl[2] = add_full[16];
        e_fl[3] = (~(x_a[15] ^ x_b[15])) & (x_a[15] ^ add_full[15]);
      end
      OP_SUB, OP_CMP: begin
        e_res = sub_r; e_we = (op == OP_SUB);
        e_fl = zn(sub_r);
        if (op == OP_CMP) begin
          e_fl[2] = d >= a;
          e_fl[3] = (d[15] ^ a[15]) & (d[15] ^ sub_r[15]);
        end else begin
          e_fl[2] = a >= b;
          e_fl[3] = (a[15] ^ b[15]) & (a[15] ^ sub_r[15]);
        end
      end
      OP_MUL: begin
        e_res = prod[15:0]; e_we = 1'b1;
        e_fl = zn(prod[15:0]); e_fl[2] = prod[31:16] != 16'd0;
      end
      OP_DIV, OP_MOD: if (b == 16'd0) e_st = ST_FAULT;
      OP_AND: begin e_res = a & b; e_we = 1'b1; e_fl = zn(a & b); end
      OP_OR:  begin e_res = a | b; e_we = 1'b1; e_fl = zn(a | b); end
      OP_XOR: begin e_res = a ^ b; e_we = 1'b1; e_fl = zn(a ^ b); end
      OP_SHL: begin
        e_res = a << b[3:0]; e_we = 1'b1; e_fl = zn(a << b[3:0]);
      end
      OP_SHR: begin e_res = shr_r; e_we = 1'b1; e_fl = zn(shr_r); end
      OP_ASR: begin
        e_res = 16'($signed(a) >>> b[3:0]); e_we = 1'b1; e_fl = zn(e_res);
      end
      OP_LD:  begin e_res = ld_val; e_we = 1'b1; end
      OP_ST:  ;
      OP_LDI: begin e_res = {8'd0, imm}; e_we = 1'b1; end
      OP_LUI: begin e_res = {imm, d[7:0]}; e_we = 1'b1; end
      OP_BR:  if (take) e_pc = pc1 + imm;
      OP_JMP: e_pc = d[7:0];
      OP_CALL: begin
        if (int'(sp) >= STACK_DEPTH) e_st = ST_FAULT;
        else begin e_pc = d[7:0]; e_push = 1'b1; end
      end
      OP_RET: begin
        if (sp == '0 || int'(sp) > STACK_DEPTH) e_st = ST_FAULT;
        else begin e_pc = stk[STK_AW'(sp - SP_W'(1))]; e_pop = 1'b1; end
      end
      OP_IN: begin
        e_res = epv ? epval : ports[imm[2:0]]; e_we = 1'b1;
      end
      OP_OUT: ;
      default: e_st = ST_FAULT;
    endcase
  end

  assign stat.running  = run_ok;
  assign stat.is_div   = (op == OP_DIV || op == OP_MOD) && b != 16'd0;
  assign stat.div_done = div_done;

  logic [31:0] count_inc;
  assign count_inc = count + 32'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 1; k < NUM_REGS_DEF; k++) regs[k] <= '0;
      for (int k = 0; k < NUM_PORTS; k++) ports[k] <= '0;
      flags <= '0; pc <= '0; sp <= '0; status <= ST_RUN; count <= '0;
      dm_vld <= '0;
      sp_push <= 1'b0; sp_pop <= 1'b0;
      port_write_valid <= 1'b0;
    end else begin
      if (cmd.capture) begin
        op <= opcode; rd <= dest_reg;
        imm <= immediate; epv <= ext_port_valid; epval <= ext_port_value;
        a <= cap_a; b <= rd_reg(second_reg, rb);
        d <= rd_reg(dest_reg, rdd);
        ld_vld <= dm_vld[cap_a[7:0]];
        run_ok <= (status == ST_RUN) && (count < step_limit);
        if (status == ST_RUN && count >= step_limit) status <= ST_TIMEOUT;
      end
      if (cmd.exec) begin
        res <= e_res; res_we <= e_we; fl_n <= e_fl; pc_n <= e_pc; st_n <= e_st;
        sp_push <= e_push; sp_pop <= e_pop;
      end
      if (div_done) begin
        res <= (op == OP_DIV) ? dq : dr;
        fl_n <= zn((op == OP_DIV) ? dq : dr);
        res_we <= 1'b1;
      end
      if (cmd.commit) begin
        port_write_valid <= 1'b0;
        if (run_ok) begin
          if (res_we && rd != 3'd0 && int'(rd) < NUM_REGS) regs[rd] <= res;
          flags <= fl_n;
          pc    <= pc_n;
          if (sp_push) begin
            stk[STK_AW'(sp)] <= pc + 8'd1;
            sp <= sp + SP_W'(1);
          end
          if (sp_pop) sp <= sp - SP_W'(1);
          if (op == OP_ST) dm_vld[d[7:0]] <= 1'b1;
          if (op == OP_IN && epv) ports[imm[2:0]] <= epval;
          if (op == OP_OUT) begin
            ports[imm[2:0]]  <= d;
            port_write_valid <= 1'b1;
          end
          count <= count_inc;
          status <= (st_n == ST_RUN && count_inc >= step_limit) ? ST_TIMEOUT : st_n;
        end
      end
    end
  end

  assign next_pc    = pc;
  assign run_status = status;
  assign flag_bits  = flags;
  assign port_write_index = port_write_valid ? imm[2:0] : 3'd0;
  assign port_write_value = port_write_valid ? d : 16'd0;

`ifndef SYNTH
  a_sp_range: assert property (@(posedge clk) disable iff (rst)
    int'(sp) <= STACK_DEPTH)
    else $error("stack pointer out of range");
  a_halted_pc: assert property (@(posedge clk) disable iff (rst)
    (cmd.commit && !run_ok) |=> $stable(pc))
    else $error("pc moved while stopped");
  a_push_pop: assert property (@(posedge clk) disable iff (rst)
    !(sp_push && sp_pop))
    else $error("push and pop together");
`endif
endmodule
`default_nettype wire

FILE: rtl/sixteen_bit_cpu_execute_step.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sixteen_bit_cpu_execute_step
// Execute stage of a small 16-bit machine, one pre-decoded instruction a step.
// ----------------------------------------------------------------------------
// An accepted instruction passes through the execute and commit states, and
// its result is then registered and held in the output state until it is
// taken. The next instruction can enter at the edge its result is taken, and
// not before. Divide and modulo also pass through a divide wait state for the
// one-bit-per-cycle divider. Data memory is a single-port RAM with a valid
// bit per word to present zeros after reset.
module sixteen_bit_cpu_execute_step #(
  parameter int NUM_REGS    = scpu_pkg::NUM_REGS_DEF,
  parameter int STACK_DEPTH = scpu_pkg::STACK_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [1:0]  paddr,
  input  wire logic [31:0] pwdata,
  output      logic [31:0] prdata,
  output      logic        pready,
  input  wire logic        in_valid,
  output      logic        in_stall,
  input  wire logic [4:0]  opcode,
  input  wire logic [2:0]  dest_reg,
  input  wire logic [2:0]  src_reg,
  input  wire logic [2:0]  second_reg,
  input  wire logic [7:0]  immediate,
  input  wire logic        ext_port_valid,
  input  wire logic [15:0] ext_port_value,
  output      logic        out_valid,
  input  wire logic        out_stall,
  output      logic [7:0]  next_pc,
  output      logic [1:0]  run_status,
  output      logic [3:0]  flag_bits,
  output      logic        port_write_valid,
  output      logic [2:0]  port_write_index,
  output      logic [15:0] port_write_value
);
  import scpu_pkg::*;

  logic [31:0] step_limit;
  dp_cmd_t  cmd;
  dp_stat_t stat;

  // configuration register
  assign pready = 1'b1;
  assign prdata = (paddr == {REG_STEP_LIMIT}) ? step_limit : 32'd0;
  always_ff @(posedge clk) begin
    if (rst) step_limit <= STEP_LIMIT_RST;
    else if (psel && penable && pwrite && paddr == {REG_STEP_LIMIT})
      step_limit <= pwdata;
  end

  scpu_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .out_stall(out_stall), .out_valid(out_valid), .cmd(cmd), .stat(stat)
  );

  scpu_dp #(.NUM_REGS(NUM_REGS), .STACK_DEPTH(STACK_DEPTH)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .stat(stat), .step_limit(step_limit),
    .opcode(opcode), .dest_reg(dest_reg), .src_reg(src_reg),
    .second_reg(second_reg), .immediate(immediate),
    .ext_port_valid(ext_port_valid), .ext_port_value(ext_port_value),
    .next_pc(next_pc), .run_status(run_status), .flag_bits(flag_bits),
    .port_write_valid(port_write_valid), .port_write_index(port_write_index),
    .port_write_value(port_write_value)
  );
endmodule
`default_nettype wire

FILE: bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the 16-bit machine execute step. Instructions go in
// over a valid/stall channel with random gaps. Each accepted instruction is
// run through an in-bench model of the machine; its outcome, or a fixed one
// for some directed items, is queued. Results are compared field by field
// against that queue. A short directed program precedes constrained-random
// programs. The run ends with one terminal event: halt, fault or timeout.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import scpu_pkg::*;

  typedef struct packed {
    logic [4:0]  op;
    logic [2:0]  rd;
    logic [2:0]  rs;
    logic [2:0]  rt;
    logic [7:0]  imm;
    logic        epv;
    logic [15:0] epval;
  } instr_t;

  typedef struct packed {
    logic [7:0]  pc;
    logic [1:0]  stat;
    logic [3:0]  flg;
    logic        pwv;
    logic [2:0]  pwi;
    logic [15:0] pwval;
  } outcome_t;

  typedef struct packed {
    instr_t   ins;
    logic     fixed;
    outcome_t res;
  } row_t;

  logic        clk = 0;
  logic        rst;
  logic        psel, penable, pwrite;
  logic [1:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid, in_stall;
  logic [4:0]  opcode;
  logic [2:0]  dest_reg, src_reg, second_reg;
  logic [7:0]  immediate;
  logic        ext_port_valid;
  logic [15:0] ext_port_value;
  logic        out_valid, out_stall;
  logic [7:0]  next_pc;
  logic [1:0]  run_status;
  logic [3:0]  flag_bits;
  logic        port_write_valid;
  logic [2:0]  port_write_index;
  logic [15:0] port_write_value;

  sixteen_bit_cpu_execute_step i_dut (.*);

  always #5 clk = ~clk;

  // machine model state
  logic [15:0] regs_m [8];
  logic [15:0] dmem_m [256];
  logic [15:0] ports_m [8];
  logic [7:0]  rstack_m [16];
  logic [3:0]  flags_m;
  logic [7:0]  pc_m;
  int          sp_m;
  logic [1:0]  stat_m;
  logic [31:0] count_m;
  logic [31:0] limit_m;

  outcome_t expected_q[$];
  int       n_errors = 0;
  int       n_results = 0;
  int       n_sent = 0;
  int       hold_left = 0;

  // ---------------- model ----------------
  function automatic logic [3:0] zn_flags(logic [15:0] v);
    return {2'b00, v[15], v == 16'h0};
  endfunction

  function automatic logic [3:0] add_flags(logic [15:0] a, logic [15:0] b);
    logic [16:0] sum;
    logic [15:0] ov;
    sum = {1'b0, a} + {1'b0, b};
    ov  = ~(a ^ b) & (a ^ sum[15:0]);
    return {ov[15], sum[16], sum[15], sum[15:0] == 16'h0};
  endfunction

  function automatic logic [3:0] sub_flags(logic [15:0] a, logic [15:0] b);
    logic [15:0] r, ov;
    r  = a - b;
    ov = (a ^ b) & (a ^ r);
    return {ov[15], a >= b, r[15], r == 16'h0};
  endfunction

  function automatic void put_reg(logic [2:0] i, logic [15:0] v);
    if (i != 0) regs_m[i] = v;
  endfunction

  function automatic outcome_t execute_instr(instr_t it);
    outcome_t    r;
    logic [15:0] a, b, d, simm, res;
    logic [31:0] prod;
    logic [2:0]  prt;
    logic        take;
    int          x, y;
    r    = '0;
    simm = {{8{it.imm[7]}}, it.imm};
    prt  = it.imm[2:0];
    if (stat_m == ST_RUN && count_m >= limit_m) stat_m = ST_TIMEOUT;
    if (stat_m == ST_RUN) begin
      a = regs_m[it.rs];
      b = regs_m[it.rt];
      d = regs_m[it.rd];
      pc_m = pc_m + 8'd1;
      case (it.op)
        OP_NOP: ;
        OP_HLT: stat_m = ST_HALT;
        OP_ADD: begin flags_m = add_flags(a, b); put_reg(it.rd, a + b); end
        OP_SUB: begin flags_m = sub_flags(a, b); put_reg(it.rd, a - b); end
        OP_MUL: begin
          prod = {16'h0, a} * {16'h0, b};
          flags_m = {1'b0, prod > 32'hFFFF, prod[15], prod[15:0] == 16'h0};
          put_reg(it.rd, prod[15:0]);
        end
        OP_DIV, OP_MOD: begin
          if (b == 16'h0) begin
            stat_m = ST_FAULT;
          end else begin
            x = $signed(a);
            y = $signed(b);
            res = (it.op == OP_DIV) ? 16'(x / y) : 16'(x % y);
            flags_m = zn_flags(res);
            put_reg(it.rd, res);
          end
        end
        OP_AND: begin flags_m = zn_flags(a & b); put_reg(it.rd, a & b); end
        OP_OR:  begin flags_m = zn_flags(a | b); put_reg(it.rd, a | b); end
        OP_XOR: begin flags_m = zn_flags(a ^ b); put_reg(it.rd, a ^ b); end
        OP_SHL, OP_SHR, OP_ASR: begin
          if (it.op == OP_SHL) res = a << b[3:0];
          else if (it.op == OP_SHR) res = a >> b[3:0];
          else res = $signed(a) >>> b[3:0];
          flags_m = zn_flags(res);
          put_reg(it.rd, res);
        end
        OP_CMP: flags_m = sub_flags(d, a);
        OP_LD:  put_reg(it.rd, dmem_m[a[7:0]]);
        OP_ST:  dmem_m[d[7:0]] = a;
        OP_LDI: put_reg(it.rd, {8'h00, it.imm});
        OP_LUI: put_reg(it.rd, {it.imm, d[7:0]});
        OP_ADDI: begin flags_m = add_flags(d, simm); put_reg(it.rd, d + simm); end
        OP_BR: begin
          case (it.rd)
            BC_AL:   take = 1'b1;
            BC_EQ:   take = flags_m[0];
            BC_NE:   take = !flags_m[0];
            BC_LT:   take = flags_m[1] != flags_m[3];
            BC_GE:   take = flags_m[1] == flags_m[3];
            BC_LTU:  take = !flags_m[2];
            BC_GEU:  take = flags_m[2];
            default: take = 1'b0;
          endcase
          if (take) pc_m = pc_m + simm[7:0];
        end
        OP_JMP: pc_m = d[7:0];
        OP_CALL: begin
          if (sp_m >= 16) stat_m = ST_FAULT;
          else begin
            rstack_m[sp_m] = pc_m;
            sp_m++;
            pc_m = d[7:0];
          end
        end
        OP_RET: begin
          if (sp_m == 0) stat_m = ST_FAULT;
          else begin
            sp_m--;
            pc_m = rstack_m[sp_m];
          end
        end
        OP_IN: begin
          if (it.epv) ports_m[prt] = it.epval;
          put_reg(it.rd, ports_m[prt]);
        end
        OP_OUT: begin
          ports_m[prt] = d;
          r.pwv = 1'b1;
          r.pwi = prt;
          r.pwval = d;
        end
        default: stat_m = ST_FAULT;
      endcase
      count_m++;
      if (stat_m == ST_RUN && count_m >= limit_m) stat_m = ST_TIMEOUT;
    end
    r.pc   = pc_m;
    r.stat = stat_m;
    r.flg  = flags_m;
    return r;
  endfunction

  // ---------------- stimulus helpers ----------------
  function automatic int pick_gap();
    int k;
    if ((n_sent / 128) % 3 == 0) return 0;
    k = $urandom_range(0, 99);
    if (k < 60) return 0;
    if (k < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [7:0] rand_imm();
    logic [7:0] edges [4] = '{8'h00, 8'h7F, 8'h80, 8'hFF};
    if ($urandom_range(0, 7) == 0) return edges[$urandom_range(0, 3)];
    return 8'($urandom);
  endfunction

  // random instruction that keeps the machine running
  function automatic instr_t rand_instr();
    instr_t it;
    int     k;
    it.op    = 5'($urandom_range(0, 24));
    it.rd    = 3'($urandom);
    it.rs    = 3'($urandom);
    it.rt    = 3'($urandom);
    it.imm   = rand_imm();
    it.epv   = 1'($urandom);
    it.epval = ($urandom_range(0, 7) == 0) ? 16'hFFFF : 16'($urandom);
    if (it.op == OP_HLT) it.op = OP_LDI;
    if ((it.op == OP_DIV || it.op == OP_MOD) && regs_m[it.rt] == 16'h0) begin
      it.op = OP_LUI;
      for (k = 1; k < 8; k++)
        if (regs_m[k] != 16'h0) begin
          it.rt = 3'(k);
          it.op = ($urandom_range(0, 1) == 0) ? OP_DIV : OP_MOD;
        end
    end
    if (it.op == OP_CALL && sp_m >= 16) it.op = OP_RET;
    if (it.op == OP_RET && sp_m == 0) it.op = OP_CALL;
    return it;
  endfunction

  // one input transfer; model runs on acceptance
  task automatic send_instr(instr_t it, logic fixed = 1'b0, outcome_t res = '0);
    outcome_t r;
    int       g;
    in_valid       <= 1'b1;
    opcode         <= it.op;
    dest_reg       <= it.rd;
    src_reg        <= it.rs;
    second_reg     <= it.rt;
    immediate      <= it.imm;
    ext_port_valid <= it.epv;
    ext_port_value <= it.epval;
    do @(posedge clk); while (in_stall);
    r = execute_instr(it);
    expected_q.push_back(fixed ? res : r);
    n_sent++;
    g = pick_gap();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic write_limit(logic [31:0] v);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    paddr   <= REG_STEP_LIMIT;
    pwdata  <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    limit_m = v;
  endtask

  function automatic instr_t mk(opcode_t op, int rd, int rs, int rt, int imm,
                                int epv = 0, int epval = 0);
    instr_t it;
    it.op = op; it.rd = 3'(rd); it.rs = 3'(rs); it.rt = 3'(rt);
    it.imm = 8'(imm); it.epv = 1'(epv); it.epval = 16'(epval);
    return it;
  endfunction

  // ---------------- result checking and receiver stalls ----------------
  always @(posedge clk) begin
    outcome_t e, got;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        got = {next_pc, run_status, flag_bits, port_write_valid,
               port_write_index, port_write_value};
        n_results++;
        if (expected_q.size() == 0) begin
          n_errors++;
          if (n_errors <= 10) $display("unexpected result: %h", got);
        end else begin
          e = expected_q.pop_front();
          if (got != e) begin
            n_errors++;
            if (n_errors <= 10)
              $display("mismatch #%0d: pc %h/%h st %h/%h fl %h/%h pw %b/%b %h/%h %h/%h",
                       n_results, e.pc, got.pc, e.stat, got.stat, e.flg, got.flg,
                       e.pwv, got.pwv, e.pwi, got.pwi, e.pwval, got.pwval);
          end
        end
      end
      // one long hold-off so the block backs up into its input
      if (n_results == 400 && hold_left == 0 && !out_stall) begin
        hold_left = 300;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if ((n_results / 100) % 3 == 1) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(0, 99) < 25) ? 1'b1 :
                     ($urandom_range(0, 99) < 3);
      end
    end
  end

  // ---------------- main sequence ----------------
  row_t prog [$];

  initial begin
    int     k, which;
    rst <= 1'b1; psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    paddr <= '0; pwdata <= '0; in_valid <= 1'b0;
    opcode <= '0; dest_reg <= '0; src_reg <= '0; second_reg <= '0;
    immediate <= '0; ext_port_valid <= 1'b0; ext_port_value <= '0;
    for (k = 0; k < 8; k++) begin regs_m[k] = '0; ports_m[k] = '0; end
    for (k = 0; k < 256; k++) dmem_m[k] = '0;
    for (k = 0; k < 16; k++) rstack_m[k] = '0;
    flags_m = '0; pc_m = '0; sp_m = 0; stat_m = ST_RUN;
    count_m = '0; limit_m = STEP_LIMIT_RST;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    write_limit(32'hFFFF_FFFF);

    // directed program: edge values and every running opcode but JMP
    prog.push_back({mk(OP_NOP, 0, 0, 0, 0), 1'b1, {8'd1, ST_RUN, 4'h0, 1'b0, 3'd0, 16'h0}});
    prog.push_back({mk(OP_LDI, 1, 0, 0, 8'hFF), 1'b1,
                    {8'd2, ST_RUN, 4'h0, 1'b0, 3'd0, 16'h0}});
    prog.push_back({mk(OP_OUT, 1, 0, 0, 8'hFF), 1'b1,
                    {8'd3, ST_RUN, 4'h0, 1'b1, 3'd7, 16'h00FF}});
    prog.push_back({mk(OP_LUI, 2, 0, 0, 8'h80), 1'b0, outcome_t'(0)});
    prog.push_back({mk(OP_ADDI, 3, 0, 0, 8'hFF), 1'b0, outcome_t'(0)});
    prog.push_back({mk(OP_DIV, 4, 2, 3, 0), 1'b0, outcome_t'(0)});
    prog.push_back({mk(OP_MOD, 5, 2, 3, 0), 1'b0, outcome_t'(0)});
    prog.push_back({mk(OP_ADD, 6, 3, 3, 0), 1'b0, outcome_t'(0)});
    prog.push_back({mk(OP_SUB, 6, 2, 1, 0), 1'b0, outcome_t'(0)});
    prog.push_back({mk(OP_MUL, 6, 3, 3, 0), 1'b0, outcome_t'(0)});
    prog.push_back({mk(OP_AND, 6, 2, 3, 0), 1'b0, outcome_t'(0)});
    prog.push_back({mk(OP_OR, 0, 2, 1, 0), 1'b0, outcome_t'(0)});
    prog.push_back({mk(OP_XOR, 6, 3, 3, 0), 1'b0, outcome_t'(0)});
    prog.push_back({mk(OP_SHL, 6, 3, 1, 0), 1'b0, outcome_t'(0)});
    prog.push_back({mk(OP_SHR, 6, 2, 1, 0), 1'b0, outcome_t'(0)});
    prog.push_back({mk(OP_ASR, 6, 2, 1, 0), 1'b0, outcome_t'(0)});
    prog.push_back({mk(OP_CMP, 2, 3, 0, 0), 1'b0, outcome_t'(0)});
    prog.push_back({mk(OP_BR, BC_LT, 0, 0, 8'h80), 1'b0, outcome_t'(0)});
    prog.push_back({mk(OP_BR, BC_NV, 0, 0, 8'h7F), 1'b0, outcome_t'(0)});
    prog.push_back({mk(OP_ST, 1, 3, 0, 0), 1'b0, outcome_t'(0)});
    prog.push_back({mk(OP_LD, 7, 1, 0, 0), 1'b0, outcome_t'(0)});
    prog.push_back({mk(OP_IN, 7, 0, 0, 8'h07, 1, 16'hFFFF), 1'b0, outcome_t'(0)});
    prog.push_back({mk(OP_IN, 7, 0, 0, 8'h00), 1'b0, outcome_t'(0)});
    prog.push_back({mk(OP_CALL, 1, 0, 0, 0), 1'b0, outcome_t'(0)});
    prog.push_back({mk(OP_RET, 0, 0, 0, 0), 1'b0, outcome_t'(0)});
    foreach (prog[i]) send_instr(prog[i].ins, prog[i].fixed, prog[i].res);
    wait_idle();
    write_limit(32'h8000_0000);

    // random programs, limit changed halfway
    for (k = 0; k < 1400; k++) begin
      if (k == 700) begin
        wait_idle();
        write_limit(32'hFFFF_FFFE);
      end
      send_instr(rand_instr());
    end
    wait_idle();

    // one terminal event, then a few items; a delayed timeout stops the machine among them
    which = $urandom_range(0, 7);
    case (which)
      0: send_instr(mk(OP_HLT, 0, 0, 0, 0));
      1: send_instr(mk(OP_DIV, 1, 2, 0, 0));
      2: send_instr(mk(OP_MOD, 1, 2, 0, 0));
      3: send_instr(mk(opcode_t'(5'($urandom_range(25, 31))), 0, 0, 0, 0));
      4: begin
        while (sp_m > 0) send_instr(mk(OP_RET, 0, 0, 0, 0));
        send_instr(mk(OP_RET, 0, 0, 0, 0));
      end
      5: begin
        while (sp_m < 16) send_instr(mk(OP_CALL, $urandom_range(0, 7), 0, 0, 0));
        send_instr(mk(OP_CALL, 0, 0, 0, 0));
      end
      6: begin
        write_limit(count_m + 32'd3);
      end
      default: begin
        write_limit(32'h0);
      end
    endcase
    for (k = 0; k < 8; k++) send_instr(rand_instr());
    wait_idle();

    if (n_errors == 0 && expected_q.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // watchdog
  initial begin
    #20ms;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
